// File: rtl/core/assert_macros.svh
// Assertion macros for the deframer RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed (same cycle)");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed (next cycle)");

`endif

// File: rtl/core/dfcd_pkg.sv
// Types, character codes and helpers for the dollar-framed deframer.
// No dependencies; used by every other file of the block but assert_macros.svh.
`timescale 1ns / 1ps

package dfcd_pkg;

  localparam int BYTE_W           = 8;
  localparam int FRAME_LEN_W      = 7;
  localparam int CAPACITY_DEFAULT = 64;

  localparam logic [BYTE_W-1:0] CH_START  = 8'h24;  // '$'
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [BYTE_W-1:0] CH_MARK   = 8'h26;  // '&'
  localparam logic [BYTE_W-1:0] SUM_GOOD  = 8'hFF;
  localparam int                MIN_BYTES = 3;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COLLECT,
    ST_JUDGE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                   result_kind;
    logic [BYTE_W-1:0]      payload_byte;
    logic [FRAME_LEN_W-1:0] frame_length;
    logic                   last_of_frame;
  } result_t;

  typedef struct packed {
    state_t                 state;
    logic [FRAME_LEN_W-1:0] count;
  } ctrl_stat_t;

  function automatic logic is_term(input logic [BYTE_W-1:0] b);
    return b inside {CH_LF, CH_CR, CH_STAR};
  endfunction

endpackage

// File: rtl/core/dfcd_if.sv
// Valid/ready channel interfaces of the deframer: bytes in, results out, config.
// Depends on dfcd_pkg for field widths.
`timescale 1ns / 1ps

interface dfcd_byte_if;
  logic                          valid;
  logic                          ready;
  logic [dfcd_pkg::BYTE_W-1:0]   rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfcd_result_if;
  logic                             valid;
  logic                             ready;
  logic                             result_kind;
  logic [dfcd_pkg::BYTE_W-1:0]      payload_byte;
  logic [dfcd_pkg::FRAME_LEN_W-1:0] frame_length;
  logic                             last_of_frame;
  modport source (output valid, output result_kind, output payload_byte,
                  output frame_length, output last_of_frame, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input frame_length, input last_of_frame, output ready);
endinterface

interface dfcd_cfg_if;
  logic valid;
  logic ready;
  logic marker_bypass_enable;
  modport source (output valid, output marker_bypass_enable, input ready);
  modport sink   (input valid, input marker_bypass_enable, output ready);
endinterface

// File: rtl/core/dfcd_store.sv
// Payload store: one write port, one read port, registered read data.
// Depends on dfcd_pkg for the byte width.
`timescale 1ns / 1ps

module dfcd_store #(
  parameter int DEPTH = dfcd_pkg::CAPACITY_DEFAULT
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  logic [dfcd_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  output logic [dfcd_pkg::BYTE_W-1:0] rd_data
);

  logic [dfcd_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [dfcd_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the last read word until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/dfcd_ctrl.sv
// Frame sequencer: collects bytes into the store, judges the frame, reads it out or reports a reject.
// Depends on dfcd_pkg and the byte channel interface in dfcd_if.
`timescale 1ns / 1ps

module dfcd_ctrl #(
  parameter int CAPACITY = dfcd_pkg::CAPACITY_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  dfcd_byte_if.sink                    in_ch,
  input  logic                         bypass,
  output logic                         wr_en,
  output logic [$clog2(CAPACITY)-1:0]  wr_addr,
  output logic [dfcd_pkg::BYTE_W-1:0]  wr_data,
  output logic                         rd_en,
  output logic [$clog2(CAPACITY)-1:0]  rd_addr,
  input  logic [dfcd_pkg::BYTE_W-1:0]  rd_data,
  input  logic                         slot_free,
  output logic                         load,
  output dfcd_pkg::result_t            load_data,
  output dfcd_pkg::ctrl_stat_t         stat
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  dfcd_pkg::state_t            state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [CNT_W-1:0]            rd_cnt_r, rd_cnt_nxt;
  logic [dfcd_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic [dfcd_pkg::BYTE_W-1:0] last_r, last_nxt;
  logic                        ovf_r, ovf_nxt;

  logic accept, is_start, is_term, short_frame, has_room, frame_ok, emit_last;

  assign in_ch.ready = (state_r == dfcd_pkg::ST_IDLE) || (state_r == dfcd_pkg::ST_COLLECT);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_start    = (in_ch.rx_byte == dfcd_pkg::CH_START);
  assign is_term     = dfcd_pkg::is_term(in_ch.rx_byte);
  assign short_frame = count_r < CNT_W'(dfcd_pkg::MIN_BYTES);
  assign has_room    = count_r < CNT_W'(CAPACITY);
  assign frame_ok    = !ovf_r && ((sum_r == dfcd_pkg::SUM_GOOD) ||
                                  (bypass && (last_r == dfcd_pkg::CH_MARK)));
  assign emit_last   = (rd_cnt_r + CNT_W'(1)) == count_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dfcd_pkg::ST_IDLE, dfcd_pkg::ST_COLLECT: begin
        if (accept) begin
          if (is_start) begin
            state_nxt = dfcd_pkg::ST_COLLECT;
          end else if (is_term) begin
            state_nxt = short_frame ? dfcd_pkg::ST_IDLE : dfcd_pkg::ST_JUDGE;
          end
        end
      end
      dfcd_pkg::ST_JUDGE: begin
        if (frame_ok) begin
          state_nxt = dfcd_pkg::ST_EMIT;
        end else if (slot_free) begin
          state_nxt = dfcd_pkg::ST_IDLE;
        end
      end
      dfcd_pkg::ST_EMIT: begin
        if (slot_free && emit_last) begin
          state_nxt = dfcd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dfcd_pkg::ST_IDLE;
    endcase
  end

  // Outputs and frame registers.
  always_comb begin
    count_nxt  = count_r;
    rd_cnt_nxt = rd_cnt_r;
    sum_nxt    = sum_r;
    last_nxt   = last_r;
    ovf_nxt    = ovf_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    load       = 1'b0;
    load_data  = '{result_kind:   dfcd_pkg::KIND_DATA,
                   payload_byte:  rd_data,
                   frame_length:  dfcd_pkg::FRAME_LEN_W'(count_r),
                   last_of_frame: emit_last};
    case (state_r)
      dfcd_pkg::ST_IDLE, dfcd_pkg::ST_COLLECT: begin
        if (accept) begin
          if (is_start) begin
            count_nxt = '0;
            sum_nxt   = '0;
            ovf_nxt   = 1'b0;
          end else if (!is_term && (state_r == dfcd_pkg::ST_COLLECT)) begin
            if (has_room) begin
              wr_en     = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              sum_nxt   = sum_r + in_ch.rx_byte;
              last_nxt  = in_ch.rx_byte;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end
      dfcd_pkg::ST_JUDGE: begin
        if (frame_ok) begin
          rd_cnt_nxt = '0;
          rd_en      = 1'b1;
        end else if (slot_free) begin
          load                    = 1'b1;
          load_data.result_kind   = dfcd_pkg::KIND_REJECT;
          load_data.payload_byte  = '0;
          load_data.last_of_frame = 1'b1;
          count_nxt               = '0;
          sum_nxt                 = '0;
          ovf_nxt                 = 1'b0;
        end
      end
      dfcd_pkg::ST_EMIT: begin
        if (slot_free) begin
          load = 1'b1;
          if (emit_last) begin
            count_nxt = '0;
            sum_nxt   = '0;
            ovf_nxt   = 1'b0;
          end else begin
            // Fetch the next byte while this one goes out.
            rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
            rd_en      = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Reads and writes never meet on one entry: writes only while collecting,
  // reads only while judging and emitting.
  assign wr_addr = count_r[AW-1:0];
  assign wr_data = in_ch.rx_byte;
  assign rd_addr = rd_cnt_nxt[AW-1:0];

  assign stat = '{state: state_r, count: dfcd_pkg::FRAME_LEN_W'(count_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dfcd_pkg::ST_IDLE;
      count_r  <= '0;
      rd_cnt_r <= '0;
      sum_r    <= '0;
      ovf_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      sum_r    <= sum_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
  end

endmodule

// File: rtl/core/dfcd_outreg.sv
// Output holding register: decouples the sequencer from a stalling receiver.
// Depends on dfcd_pkg and dfcd_result_if.
`timescale 1ns / 1ps

module dfcd_outreg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  dfcd_pkg::result_t load_data,
  output logic              slot_free,
  dfcd_result_if.source     out_ch
);

  logic              valid_r, valid_nxt;
  dfcd_pkg::result_t data_r;

  assign slot_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.result_kind   = data_r.result_kind;
  assign out_ch.payload_byte  = data_r.payload_byte;
  assign out_ch.frame_length  = data_r.frame_length;
  assign out_ch.last_of_frame = data_r.last_of_frame;

endmodule

// File: rtl/core/dollar_framed_checksum_deframer_core.sv
// Dollar-framed checksum deframer, top level.
// in_ch takes one received byte per word. '$' opens a frame; following bytes
// are written into the payload store. A line feed, carriage return or '*'
// closes a frame of three or more bytes: it is accepted when its byte sum is
// 0xFF, or, with the bypass bit set, when its last byte is '&'.
// out_ch gives an accepted frame as one word per stored byte (last_of_frame
// on the final one), or a single reject word for a failing or overfull frame.
// cfg_ch writes the bypass bit; write it only while the block is idle.
// Flow: ordinary bytes are taken whenever the sequencer is idle or
// collecting. A closing byte parks the input for the judge state plus the
// read-out. The judge state reads the first stored byte (a reject word is
// loaded there instead); the emit state loads it into the output register,
// then one word a cycle while the output register has room, each next byte
// fetched from the store while the current one goes out.
// Stalls: an output register holds the pending word; the read-out waits for
// it and the input stays parked until the frame is out. Between frames
// ordinary bytes keep flowing in. Reset (rst_n low, synchronous) returns to
// idle with the bypass bit set; the store is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dollar_framed_checksum_deframer_core #(
  parameter int PAYLOAD_CAPACITY = dfcd_pkg::CAPACITY_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  dfcd_byte_if.sink     in_ch,
  dfcd_result_if.source out_ch,
  dfcd_cfg_if.sink      cfg_ch
);

  localparam int AW = $clog2(PAYLOAD_CAPACITY);

  logic                        bypass_r, bypass_nxt;
  logic                        wr_en, rd_en, slot_free, load;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [dfcd_pkg::BYTE_W-1:0] wr_data, rd_data;
  dfcd_pkg::result_t           load_data;
  dfcd_pkg::ctrl_stat_t        stat;

  // Configuration: always ready, take the bypass bit on each write.
  assign cfg_ch.ready = 1'b1;
  assign bypass_nxt   = cfg_ch.valid ? cfg_ch.marker_bypass_enable : bypass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b1;
    end else begin
      bypass_r <= bypass_nxt;
    end
  end

  dfcd_store #(
    .DEPTH (PAYLOAD_CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dfcd_ctrl #(
    .CAPACITY (PAYLOAD_CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .bypass    (bypass_r),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .slot_free (slot_free),
    .load      (load),
    .load_data (load_data),
    .stat      (stat)
  );

  dfcd_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_data (load_data),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

  // Never overwrite a word the receiver has not taken.
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, out_ch.valid && !out_ch.ready, !load)
  // The fill count stays within the store.
  `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1,
                  stat.count <= dfcd_pkg::FRAME_LEN_W'(PAYLOAD_CAPACITY))
  // A final result always hands control back to idle.
  `ASSERT_NEXT(a_last_to_idle, clk, rst_n, load && load_data.last_of_frame,
               stat.state == dfcd_pkg::ST_IDLE)
  // A close of at least MIN_BYTES bytes always goes to judgement.
  `ASSERT_NEXT(a_close_judged, clk, rst_n,
               in_ch.valid && in_ch.ready && dfcd_pkg::is_term(in_ch.rx_byte) &&
               (stat.count >= dfcd_pkg::FRAME_LEN_W'(dfcd_pkg::MIN_BYTES)),
               stat.state == dfcd_pkg::ST_JUDGE)

endmodule

// File: tb/dollar_framed_checksum_deframer_core_tb.sv
// Self-checking bench for the deframer core: directed table, then random frames.
// Depends on dfcd_pkg, the channel interfaces in dfcd_if.sv and the deframer core files.
`timescale 1ns / 1ps

module dollar_framed_checksum_deframer_core_tb;

  localparam int CAPACITY        = dfcd_pkg::CAPACITY_DEFAULT;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int HOLD_CYCLES     = 400;   // long receiver hold-off for the pressure stretch
  localparam int SETTLE_CYCLES   = 8;     // covers a closing byte still in flight
  localparam int WATCHDOG_LIMIT  = 4000;  // well above the hold-off plus a 64-byte read-out
  localparam int REPORT_LIMIT    = 10;

  localparam dfcd_pkg::result_t NO_WORD     = '0;
  localparam dfcd_pkg::result_t REJECT_OF_3 = '{dfcd_pkg::KIND_REJECT, 8'h00, 7'd3, 1'b1};

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;
  typedef enum logic [2:0] {FR_GOOD, FR_MARK, FR_BAD, FR_SHORT, FR_OVERFLOW} frame_kind_t;

  // One row of the directed table: a byte to send or a bypass write. Where
  // typed is set, word is the result the row must produce, typed in by hand.
  typedef struct {
    row_kind_t         kind;
    logic [7:0]        value;
    bit                typed;
    dfcd_pkg::result_t word;
  } row_t;

  logic clk;
  logic rst_n;

  dfcd_byte_if   in_ch ();
  dfcd_result_if out_ch ();
  dfcd_cfg_if    cfg_ch ();

  dollar_framed_checksum_deframer_core #(
    .PAYLOAD_CAPACITY (CAPACITY)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // ---------------------------------------------------------------------------
  // Deframer prediction: own copy of the bypass bit and the frame state.
  // ---------------------------------------------------------------------------
  logic       bypass_bit     = 1'b1;
  logic       collecting     = 1'b0;
  logic [7:0] frame_store [CAPACITY];
  logic [6:0] frame_count    = '0;
  logic [7:0] frame_sum      = '0;
  logic       frame_overflow = 1'b0;

  dfcd_pkg::result_t predicted_words[$];  // words caused by the latest byte
  dfcd_pkg::result_t expected_words[$];   // words still owed by the block

  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         hold_req      = 1'b0;
  int         hold_left     = 0;
  int         mismatches    = 0;
  int         stalled_cycles = 0;
  row_t       stim_table[$];

  // Work out the words that one accepted byte causes and advance the state.
  function automatic int deframe_byte(input logic [7:0] b);
    logic ok;
    predicted_words.delete();
    if (b == dfcd_pkg::CH_START) begin
      // open (or reopen) a frame, dropping whatever was collected
      collecting     = 1'b1;
      frame_count    = '0;
      frame_sum      = '0;
      frame_overflow = 1'b0;
    end else if (b == dfcd_pkg::CH_LF || b == dfcd_pkg::CH_CR || b == dfcd_pkg::CH_STAR) begin
      // a short frame leaves the count alone; only a judged frame or a new '$' clears it
      if (frame_count >= dfcd_pkg::MIN_BYTES) begin
        ok = !frame_overflow &&
             (frame_sum == dfcd_pkg::SUM_GOOD ||
              (bypass_bit && frame_store[frame_count - 1] == dfcd_pkg::CH_MARK));
        if (ok) begin
          for (int i = 0; i < frame_count; i++)
            predicted_words.push_back('{dfcd_pkg::KIND_DATA, frame_store[i], frame_count,
                                        (i + 1 == frame_count)});
        end else begin
          predicted_words.push_back('{dfcd_pkg::KIND_REJECT, 8'h00, frame_count, 1'b1});
        end
        frame_count    = '0;
        frame_sum      = '0;
        frame_overflow = 1'b0;
      end
      collecting = 1'b0;
    end else if (collecting) begin
      if (frame_count < CAPACITY) begin
        frame_store[frame_count] = b;
        frame_count++;
        frame_sum += b;
      end else begin
        frame_overflow = 1'b1;
      end
    end
    return predicted_words.size();
  endfunction

  function automatic bit is_control(input logic [7:0] b);
    return b == dfcd_pkg::CH_START || b == dfcd_pkg::CH_LF || b == dfcd_pkg::CH_CR ||
           b == dfcd_pkg::CH_STAR;
  endfunction

  // Random payload byte that neither opens nor closes a frame.
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_control(b));
    return b;
  endfunction

  function automatic void report_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $time, what);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and drivers
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one byte, idling first at the current sender rate, and hold it
  // until the block takes it. Valid stays high afterwards; the next call
  // or a drain decides whether it drops.
  task automatic put_byte(input logic [7:0] b, input bit typed,
                          input dfcd_pkg::result_t word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    void'(deframe_byte(b));
    if (typed) begin
      expected_words.push_back(word);
    end else begin
      foreach (predicted_words[i]) expected_words.push_back(predicted_words[i]);
    end
  endtask

  // Drop valid, wait for every owed word, then let a closing byte that
  // produces nothing work its way through.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the bypass bit; only ever done with the block idle.
  task automatic set_bypass(input logic v);
    drain();
    cfg_ch.valid                <= 1'b1;
    cfg_ch.marker_bypass_enable <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    bypass_bit = v;
  endtask

  // Build and send one frame: '$', body, terminator. A good frame gets its
  // last byte chosen so the sum lands on 0xFF without being a control byte.
  task automatic send_frame(input frame_kind_t kind, input int len, inout int sent);
    logic [7:0] body[$];
    logic [7:0] sum;
    logic [7:0] fix;
    int         n;
    n = (kind == FR_GOOD || kind == FR_MARK) ? len - 1 : len;
    repeat (n) body.push_back(body_byte());
    case (kind)
      FR_GOOD: begin
        do begin
          body[0] = body_byte();
          sum = '0;
          foreach (body[i]) sum += body[i];
          fix = dfcd_pkg::SUM_GOOD - sum;
        end while (is_control(fix));
        body.push_back(fix);
      end
      FR_MARK: body.push_back(dfcd_pkg::CH_MARK);
      default: ;
    endcase
    put_byte(dfcd_pkg::CH_START, 1'b0, NO_WORD);
    foreach (body[i]) put_byte(body[i], 1'b0, NO_WORD);
    case ($urandom_range(2))
      0:       put_byte(dfcd_pkg::CH_LF, 1'b0, NO_WORD);
      1:       put_byte(dfcd_pkg::CH_CR, 1'b0, NO_WORD);
      default: put_byte(dfcd_pkg::CH_STAR, 1'b0, NO_WORD);
    endcase
    sent += body.size() + 2;
  endtask

  // Mostly well-formed frames with random content; the rest is idle noise,
  // restarted frames, bad-sum frames, short frames and overfull ones.
  task automatic run_phase(input int items);
    int          sent;
    int          r;
    int          n;
    int          len;
    frame_kind_t kind;
    sent = 0;
    while (sent < items) begin
      // noise between frames: any value, mostly ignored by the block
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(255)), 1'b0, NO_WORD);
      // an abandoned frame that the next '$' throws away
      if ($urandom_range(7) == 0) begin
        n = $urandom_range(1, 5);
        put_byte(dfcd_pkg::CH_START, 1'b0, NO_WORD);
        repeat (n) put_byte(body_byte(), 1'b0, NO_WORD);
        sent += n + 1;
      end
      r   = $urandom_range(99);
      len = ($urandom_range(29) == 0) ? CAPACITY : $urandom_range(dfcd_pkg::MIN_BYTES, 12);
      if (r < 40) begin
        kind = FR_GOOD;
      end else if (r < 55) begin
        kind = FR_MARK;
      end else if (r < 72) begin
        kind = FR_BAD;
      end else if (r < 86) begin
        kind = FR_SHORT;
        len  = $urandom_range(0, dfcd_pkg::MIN_BYTES - 1);
      end else if (r < 89) begin
        kind = FR_OVERFLOW;
        len  = CAPACITY + $urandom_range(1, 6);
      end else begin
        kind = FR_GOOD;
      end
      send_frame(kind, len, sent);
    end
  endtask

  // Receiver: stall at the current rate, or hold off entirely for a long
  // stretch when asked, so the block fills up and parks its input.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking: every accepted word against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    dfcd_pkg::result_t got;
    dfcd_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.result_kind, out_ch.payload_byte, out_ch.frame_length,
              out_ch.last_of_frame};
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word: kind=%0d byte=%02h len=%0d last=%0d",
                                  got.result_kind, got.payload_byte, got.frame_length,
                                  got.last_of_frame));
      end else begin
        want = expected_words.pop_front();
        if (got.result_kind   !== want.result_kind  ||
            got.payload_byte  !== want.payload_byte ||
            got.frame_length  !== want.frame_length ||
            got.last_of_frame !== want.last_of_frame) begin
          report_mismatch($sformatf(
            {"word mismatch: expected kind=%0d byte=%02h len=%0d last=%0d, ",
             "got kind=%0d byte=%02h len=%0d last=%0d"},
            want.result_kind, want.payload_byte, want.frame_length, want.last_of_frame,
            got.result_kind, got.payload_byte, got.frame_length, got.last_of_frame));
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word accepted for %0d cycles, %0d words still owed",
                 WATCHDOG_LIMIT, expected_words.size());
        $display("dollar_framed_checksum_deframer_core_tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int sent;
    in_ch.valid                 <= 1'b0;
    in_ch.rx_byte               <= '0;
    cfg_ch.valid                <= 1'b0;
    cfg_ch.marker_bypass_enable <= 1'b0;
    rst_n                       <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; bypass is still at its reset value of 1.
    // an idle byte, then a terminator while idle: nothing comes out
    stim_table.push_back(row_t'{ROW_BYTE, 8'h00,              1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, dfcd_pkg::CH_LF,    1'b0, NO_WORD});
    // short frame: one byte, then a terminator, returns silently to idle
    stim_table.push_back(row_t'{ROW_BYTE, dfcd_pkg::CH_START, 1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, 8'h7F,              1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, dfcd_pkg::CH_CR,    1'b0, NO_WORD});
    // start inside a frame drops the bytes; then 55+AA+00 sums to FF
    stim_table.push_back(row_t'{ROW_BYTE, dfcd_pkg::CH_START, 1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, 8'h01,              1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, dfcd_pkg::CH_START, 1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, 8'h55,              1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, 8'hAA,              1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, 8'h00,              1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, dfcd_pkg::CH_STAR,  1'b0, NO_WORD});
    // bad sum rescued by the trailing '&' while bypass is on
    stim_table.push_back(row_t'{ROW_BYTE, dfcd_pkg::CH_START, 1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, 8'h41,              1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, 8'h42,              1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, dfcd_pkg::CH_MARK,  1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, dfcd_pkg::CH_LF,    1'b0, NO_WORD});
    // bypass off: the same frame is rejected
    stim_table.push_back(row_t'{ROW_CFG,  8'h00,              1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, dfcd_pkg::CH_START, 1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, 8'h41,              1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, 8'h42,              1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, dfcd_pkg::CH_MARK,  1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, dfcd_pkg::CH_CR,    1'b1, REJECT_OF_3});
    // all-ones bytes sum to FD: rejected
    stim_table.push_back(row_t'{ROW_BYTE, dfcd_pkg::CH_START, 1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, 8'hFF,              1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, 8'hFF,              1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, 8'hFF,              1'b0, NO_WORD});
    stim_table.push_back(row_t'{ROW_BYTE, dfcd_pkg::CH_STAR,  1'b1, REJECT_OF_3});

    send_idle_pct = 16;
    recv_idle_pct = 85;
    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) set_bypass(stim_table[i].value[0]);
      else put_byte(stim_table[i].value, stim_table[i].typed, stim_table[i].word);
    end

    // Random phase one: sender mostly busy, receiver mostly stalling.
    set_bypass(1'b1);
    run_phase(ITEMS_PER_PHASE);

    // Phase two: the other way round, bypass off.
    send_idle_pct = 85;
    recv_idle_pct = 16;
    set_bypass(1'b0);
    run_phase(ITEMS_PER_PHASE);

    // Phase three: no idling; open with a full frame under a long hold-off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_bypass(1'b1);
    hold_req = 1'b1;
    sent = 0;
    send_frame(FR_GOOD, CAPACITY, sent);
    run_phase(ITEMS_PER_PHASE);

    drain();
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
    if (mismatches == 0) begin
      $display("dollar_framed_checksum_deframer_core_tb: PASS");
    end else begin
      $display("dollar_framed_checksum_deframer_core_tb: FAIL");
    end
    $finish;
  end

endmodule
